// File: rtl/alm_pkg.sv
// ----------------------------------------------------------------------------
// alm_pkg
// Shared types and constants for the array linked list manager.
// ----------------------------------------------------------------------------
package alm_pkg;

    localparam int NODES_DEF      = 256;
    localparam int DATA_WIDTH_DEF = 64;

    localparam int FUNC_W = 2;
    localparam int IDX_W  = 8;
    localparam int VAL_W  = 64;
    localparam int STAT_W = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_INS_AFTER  = 2'd0,
        FN_INS_BEFORE = 2'd1,
        FN_EXTRACT    = 2'd2,
        FN_LOCATE     = 2'd3
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

endpackage

// File: rtl/array_linked_list_manager.sv
// ----------------------------------------------------------------------------
// array_linked_list_manager
// Doubly linked list in link/data RAMs with a free list; node 0 is null.
// One item is in flight at a time; each link RAM has one read and one write port.
// After reset an init pass writes the links of every node to build the free
// chain; s_ready stays low during the pass.
// ----------------------------------------------------------------------------
module array_linked_list_manager #(
    parameter int NODES      = alm_pkg::NODES_DEF,
    parameter int DATA_WIDTH = alm_pkg::DATA_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [alm_pkg::FUNC_W-1:0] s_func,
    input  logic [alm_pkg::IDX_W-1:0]  s_node_index,
    input  logic [alm_pkg::IDX_W-1:0]  s_position,
    input  logic [alm_pkg::VAL_W-1:0]  s_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [alm_pkg::IDX_W-1:0]  m_result_node,
    output logic [alm_pkg::VAL_W-1:0]  m_data_out,
    output logic [alm_pkg::IDX_W-1:0]  m_item_count,
    output logic [alm_pkg::STAT_W-1:0] m_status
);
    import alm_pkg::*;

    localparam int AW  = $clog2(NODES);
    localparam int LCW = AW + 2;

    typedef enum logic [13:0] {
        S_INIT     = 14'b00000000000001,
        S_IDLE     = 14'b00000000000010,
        S_INS_PREV = 14'b00000000000100,
        S_INS_RDFR = 14'b00000000001000,
        S_INS_FRPV = 14'b00000000010000,
        S_INS_PVF  = 14'b00000000100000,
        S_INS_ANCH = 14'b00000001000000,
        S_INS_LINK = 14'b00000010000000,
        S_INS_FLRD = 14'b00000100000000,
        S_INS_FOL  = 14'b00001000000000,
        S_EXT_RD   = 14'b00010000000000,
        S_EXT_FREE = 14'b00100000000000,
        S_EXT_FP   = 14'b01000000000000,
        S_LOC      = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;
    logic   walk_reg, walk_next;

    logic [AW-1:0]  head_reg, head_next;
    logic [AW-1:0]  tail_reg, tail_next;
    logic [AW-1:0]  free_reg, free_next;
    logic [AW-1:0]  count_reg, count_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic           mv_reg, mv_next;

    logic [AW-1:0]         node_reg, node_next;
    logic [AW-1:0]         anchor_reg, anchor_next;
    logic [AW-1:0]         fresh_reg, fresh_next;
    logic [AW-1:0]         iter_reg, iter_next;
    logic [LCW-1:0]        cnt_reg, cnt_next;
    logic [LCW-1:0]        steps_reg, steps_next;
    logic [IDX_W-1:0]      pos_reg, pos_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [AW-1:0]         rnode_reg, rnode_next;
    logic [DATA_WIDTH-1:0] rdata_reg, rdata_next;
    status_t               rstat_reg, rstat_next;
    logic [IDX_W-1:0]      mnode_reg, mnode_next;
    logic [VAL_W-1:0]      mdata_reg, mdata_next;
    logic [IDX_W-1:0]      mcount_reg, mcount_next;
    status_t               mstat_reg, mstat_next;

    logic            nx_we, pv_we, dt_we;
    logic [AW-1:0]   nx_wa, nx_wd, nx_ra, nx_rd;
    logic [AW-1:0]   pv_wa, pv_wd, pv_ra, pv_rd;
    logic [AW-1:0]   dt_wa, dt_ra;
    logic [DATA_WIDTH-1:0] dt_wd, dt_rd;

    logic          in_acc, node_oob, list_full;
    logic [AW-1:0] node_in;
    func_t         fn;

    alm_ram #(.WIDTH(AW), .DEPTH(NODES)) u_next_ram (
        .aclk(aclk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd)
    );
    alm_ram #(.WIDTH(AW), .DEPTH(NODES)) u_prev_ram (
        .aclk(aclk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd)
    );
    alm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NODES)) u_data_ram (
        .aclk(aclk), .we(dt_we), .waddr(dt_wa), .wdata(dt_wd), .raddr(dt_ra), .rdata(dt_rd)
    );

    assign s_ready   = (state_reg == S_IDLE) && !done_reg && !walk_reg;
    assign in_acc    = s_valid && s_ready;
    assign fn        = func_t'(s_func);
    assign node_oob  = 32'(s_node_index) >= 32'(NODES);
    assign node_in   = AW'(s_node_index);
    assign list_full = (free_reg == '0) || (count_reg >= AW'(NODES - 1));

    assign m_valid       = mv_reg;
    assign m_result_node = mnode_reg;
    assign m_data_out    = mdata_reg;
    assign m_item_count  = mcount_reg;
    assign m_status      = mstat_reg;

    always_comb begin
        state_next  = state_reg;
        done_next   = done_reg;
        walk_next   = walk_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        free_next   = free_reg;
        count_next  = count_reg;
        clr_next    = clr_reg;
        mv_next     = mv_reg;
        node_next   = node_reg;
        anchor_next = anchor_reg;
        fresh_next  = fresh_reg;
        iter_next   = iter_reg;
        cnt_next    = cnt_reg;
        steps_next  = steps_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        rnode_next  = rnode_reg;
        rdata_next  = rdata_reg;
        rstat_next  = rstat_reg;
        mnode_next  = mnode_reg;
        mdata_next  = mdata_reg;
        mcount_next = mcount_reg;
        mstat_next  = mstat_reg;

        nx_we = 1'b0; nx_wa = '0; nx_wd = '0; nx_ra = '0;
        pv_we = 1'b0; pv_wa = '0; pv_wd = '0; pv_ra = '0;
        dt_we = 1'b0; dt_wa = '0; dt_wd = '0; dt_ra = '0;

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT: begin
                nx_we = 1'b1;
                nx_wa = clr_reg;
                nx_wd = (clr_reg != '0 && clr_reg < AW'(NODES - 1)) ? clr_reg + 1'b1 : '0;
                pv_we = 1'b1;
                pv_wa = clr_reg;
                pv_wd = (clr_reg > AW'(1)) ? clr_reg - 1'b1 : '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(NODES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (done_reg) begin
                    if (!mv_reg || m_ready) begin
                        mv_next     = 1'b1;
                        mnode_next  = IDX_W'(rnode_reg);
                        mdata_next  = VAL_W'(rdata_reg);
                        mcount_next = IDX_W'(count_reg);
                        mstat_next  = rstat_reg;
                        done_next   = 1'b0;
                    end
                end else if (walk_reg) begin
                    if (iter_reg == '0 || steps_reg == LCW'(NODES)) begin
                        rstat_next = ST_NOTFOUND;
                        rnode_next = '0;
                        done_next  = 1'b1;
                        walk_next  = 1'b0;
                    end else if (32'(cnt_reg) == 32'(pos_reg)) begin
                        rnode_next = iter_reg;
                        done_next  = 1'b1;
                        walk_next  = 1'b0;
                    end else begin
                        nx_ra      = iter_reg;
                        state_next = S_LOC;
                    end
                end else if (in_acc) begin
                    node_next  = node_in;
                    val_next   = DATA_WIDTH'(s_value);
                    pos_next   = s_position;
                    fresh_next = free_reg;
                    rnode_next = '0;
                    rdata_next = '0;
                    rstat_next = ST_OK;
                    case (fn)
                        FN_INS_AFTER: begin
                            if (node_oob) begin
                                rstat_next = ST_NULL;
                                done_next  = 1'b1;
                            end else if (list_full) begin
                                rstat_next = ST_FULL;
                                done_next  = 1'b1;
                            end else begin
                                anchor_next = node_in;
                                nx_ra       = free_reg;
                                state_next  = S_INS_RDFR;
                            end
                        end
                        FN_INS_BEFORE: begin
                            if (node_oob || node_in == '0) begin
                                rstat_next = ST_NULL;
                                done_next  = 1'b1;
                            end else if (list_full) begin
                                rstat_next = ST_FULL;
                                done_next  = 1'b1;
                            end else begin
                                pv_ra      = node_in;
                                state_next = S_INS_PREV;
                            end
                        end
                        FN_EXTRACT: begin
                            if (count_reg == '0) begin
                                rstat_next = ST_EMPTY;
                                done_next  = 1'b1;
                            end else if (node_oob || node_in == '0) begin
                                rstat_next = ST_NULL;
                                done_next  = 1'b1;
                            end else begin
                                nx_ra      = node_in;
                                pv_ra      = node_in;
                                dt_ra      = node_in;
                                state_next = S_EXT_RD;
                            end
                        end
                        default: begin
                            iter_next  = head_reg;
                            cnt_next   = LCW'(1);
                            steps_next = '0;
                            walk_next  = 1'b1;
                        end
                    endcase
                end
            end
            S_INS_PREV: begin
                anchor_next = pv_rd;
                nx_ra       = free_reg;
                state_next  = S_INS_RDFR;
            end
            S_INS_RDFR: begin
                free_next  = nx_rd;
                pv_we      = 1'b1;
                pv_wa      = nx_rd;
                pv_wd      = '0;
                dt_we      = 1'b1;
                dt_wa      = fresh_reg;
                dt_wd      = val_reg;
                state_next = S_INS_FRPV;
            end
            S_INS_FRPV: begin
                pv_we = 1'b1;
                pv_wa = fresh_reg;
                pv_wd = anchor_reg;
                if (anchor_reg == '0) begin
                    nx_we      = 1'b1;
                    nx_wa      = fresh_reg;
                    nx_wd      = head_reg;
                    head_next  = fresh_reg;
                    state_next = S_INS_FLRD;
                end else begin
                    nx_ra      = anchor_reg;
                    state_next = S_INS_ANCH;
                end
            end
            S_INS_ANCH: begin
                nx_we      = 1'b1;
                nx_wa      = fresh_reg;
                nx_wd      = nx_rd;
                state_next = S_INS_LINK;
            end
            S_INS_LINK: begin
                nx_we      = 1'b1;
                nx_wa      = anchor_reg;
                nx_wd      = fresh_reg;
                state_next = S_INS_FLRD;
            end
            S_INS_FLRD: begin
                nx_ra      = fresh_reg;
                state_next = S_INS_FOL;
            end
            S_INS_FOL: begin
                if (nx_rd != '0) begin
                    pv_we = 1'b1;
                    pv_wa = nx_rd;
                    pv_wd = fresh_reg;
                end
                if (anchor_reg == tail_reg) begin
                    tail_next = fresh_reg;
                end
                count_next = count_reg + 1'b1;
                rnode_next = fresh_reg;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_EXT_RD: begin
                rdata_next = dt_rd;
                if (node_reg != head_reg) begin
                    nx_we = 1'b1;
                    nx_wa = pv_rd;
                    nx_wd = nx_rd;
                end
                if (node_reg != tail_reg) begin
                    pv_we = 1'b1;
                    pv_wa = nx_rd;
                    pv_wd = pv_rd;
                end
                if (node_reg == head_reg) begin
                    head_next = nx_rd;
                end
                if (node_reg == tail_reg) begin
                    tail_next = pv_rd;
                end
                state_next = S_EXT_FREE;
            end
            S_EXT_FREE: begin
                nx_we      = 1'b1;
                nx_wa      = node_reg;
                nx_wd      = free_reg;
                pv_we      = 1'b1;
                pv_wa      = node_reg;
                pv_wd      = '0;
                state_next = S_EXT_FP;
            end
            S_EXT_FP: begin
                if (free_reg != '0) begin
                    pv_we = 1'b1;
                    pv_wa = free_reg;
                    pv_wd = node_reg;
                end
                free_next  = node_reg;
                count_next = count_reg - 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_LOC: begin
                iter_next  = nx_rd;
                cnt_next   = cnt_reg + 1'b1;
                steps_next = steps_reg + 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            done_reg  <= 1'b0;
            walk_reg  <= 1'b0;
            head_reg  <= '0;
            tail_reg  <= '0;
            free_reg  <= AW'(1);
            count_reg <= '0;
            clr_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            walk_reg  <= walk_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            free_reg  <= free_next;
            count_reg <= count_next;
            clr_reg   <= clr_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        node_reg   <= node_next;
        anchor_reg <= anchor_next;
        fresh_reg  <= fresh_next;
        iter_reg   <= iter_next;
        cnt_reg    <= cnt_next;
        steps_reg  <= steps_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        rnode_reg  <= rnode_next;
        rdata_reg  <= rdata_next;
        rstat_reg  <= rstat_next;
        mnode_reg  <= mnode_next;
        mdata_reg  <= mdata_next;
        mcount_reg <= mcount_next;
        mstat_reg  <= mstat_next;
    end

endmodule

// File: rtl/alm_ram.sv
// ----------------------------------------------------------------------------
// alm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module alm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: test/array_linked_list_manager_tb.sv
// ----------------------------------------------------------------------------
// array_linked_list_manager_tb
// Self-checking bench for the linked list manager. Insert, extract and locate
// items are predicted against a shadow list, and every returned item is
// compared field by field. The list is driven alternately toward full and
// toward empty, with random input gaps and output stalls along the way.
// ----------------------------------------------------------------------------
module array_linked_list_manager_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import alm_pkg::*;

    localparam int N        = NODES_DEF;
    localparam int WDOG_MAX = 4000;

    typedef struct {
        func_t             fn;
        logic [IDX_W-1:0]  node;
        logic [IDX_W-1:0]  pos;
        logic [VAL_W-1:0]  val;
    } op_t;

    typedef struct {
        logic [IDX_W-1:0]  node;
        logic [VAL_W-1:0]  data;
        logic [IDX_W-1:0]  count;
        status_t           st;
    } res_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [FUNC_W-1:0]   s_func = '0;
    logic [IDX_W-1:0]    s_node_index = '0;
    logic [IDX_W-1:0]    s_position = '0;
    logic [VAL_W-1:0]    s_value = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [IDX_W-1:0]    m_result_node;
    logic [VAL_W-1:0]    m_data_out;
    logic [IDX_W-1:0]    m_item_count;
    logic [STAT_W-1:0]   m_status;

    array_linked_list_manager u_top (.*);

    always #5 aclk = ~aclk;

    // shadow list
    logic [7:0]  nxt_lnk [N];
    logic [7:0]  prv_lnk [N];
    logic [63:0] node_val [N];
    bit          written [N];
    int          head_n, tail_n, free_n, list_len;

    op_t  pending_ops [$];
    res_t expected_res [$];
    int   errors = 0;
    int   results_seen = 0;
    int   status_hits [5];
    int   peak_len = 0;
    int   idle_cycles = 0;

    function automatic void shadow_reset();
        for (int i = 0; i < N; i++) begin
            nxt_lnk[i] = (i > 0 && i < N - 1) ? 8'(i + 1) : 8'd0;
            prv_lnk[i] = (i > 1) ? 8'(i - 1) : 8'd0;
            node_val[i] = '0;
            written[i] = 1'b0;
        end
        head_n = 0;
        tail_n = 0;
        free_n = 1;
        list_len = 0;
    endfunction

    function automatic int link_after(int anchor, logic [63:0] v);
        int fresh;
        int follow;
        fresh = free_n;
        free_n = nxt_lnk[fresh];
        prv_lnk[free_n] = 8'd0;
        prv_lnk[fresh] = 8'(anchor);
        node_val[fresh] = v;
        written[fresh] = 1'b1;
        if (anchor == 0) begin
            nxt_lnk[fresh] = 8'(head_n);
            head_n = fresh;
        end else begin
            nxt_lnk[fresh] = nxt_lnk[anchor];
            nxt_lnk[anchor] = 8'(fresh);
        end
        follow = nxt_lnk[fresh];
        if (follow != 0) prv_lnk[follow] = 8'(fresh);
        if (anchor == tail_n) tail_n = fresh;
        list_len++;
        return fresh;
    endfunction

    function automatic logic [63:0] unlink(int nd);
        int b;
        int a;
        logic [63:0] w;
        b = prv_lnk[nd];
        a = nxt_lnk[nd];
        w = node_val[nd];
        if (nd != head_n) nxt_lnk[b] = 8'(a);
        if (nd != tail_n) prv_lnk[a] = 8'(b);
        if (nd == head_n) head_n = a;
        if (nd == tail_n) tail_n = b;
        nxt_lnk[nd] = 8'(free_n);
        prv_lnk[nd] = 8'd0;
        if (free_n != 0) prv_lnk[free_n] = 8'(nd);
        free_n = nd;
        list_len--;
        return w;
    endfunction

    function automatic int walk_to(int pos);
        int it;
        int c;
        it = head_n;
        c = 1;
        for (int s = 0; s < N && it != 0; s++) begin
            if (c == pos) return it;
            c++;
            it = nxt_lnk[it];
        end
        return 0;
    endfunction

    function automatic res_t list_apply(op_t op);
        res_t r;
        bit full;
        r.node = '0;
        r.data = '0;
        r.st = ST_OK;
        full = (free_n == 0) || (list_len >= N - 1);
        case (op.fn)
            FN_INS_AFTER: begin
                if (full) r.st = ST_FULL;
                else r.node = 8'(link_after(op.node, op.val));
            end
            FN_INS_BEFORE: begin
                if (op.node == 0) r.st = ST_NULL;
                else if (full) r.st = ST_FULL;
                else r.node = 8'(link_after(prv_lnk[op.node], op.val));
            end
            FN_EXTRACT: begin
                if (list_len == 0) r.st = ST_EMPTY;
                else if (op.node == 0) r.st = ST_NULL;
                else r.data = unlink(op.node);
            end
            default: begin
                r.node = 8'(walk_to(op.pos));
                if (r.node == 0) r.st = ST_NOTFOUND;
            end
        endcase
        r.count = 8'(list_len);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH item %0d %s: got %0h expected %0h", results_seen, what, got, want);
        errors++;
    endtask

    // driver
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        op_t cur;
        op_t nxt_op;
        res_t r;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                cur.fn = func_t'(s_func);
                cur.node = s_node_index;
                cur.pos = s_position;
                cur.val = s_value;
                r = list_apply(cur);
                expected_res.push_back(r);
                if (list_len > peak_len) peak_len = list_len;
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
            end
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                nxt_op = pending_ops.pop_front();
                s_func <= nxt_op.fn;
                s_node_index <= nxt_op.node;
                s_position <= nxt_op.pos;
                s_value <= nxt_op.val;
                s_valid <= 1'b1;
                burst_left--;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, with one long hold-off
    int stall_pct = 0;
    int phase_left = 0;
    int hold_left = 0;
    bit held_once = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (!held_once && results_seen >= 150) begin
                held_once = 1;
                hold_left = 300;
            end
            if (phase_left == 0) begin
                phase_left = 32;
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 30;
                    default: stall_pct = 70;
                endcase
            end
            phase_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        res_t w;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_res.size() == 0) begin
                report_mismatch("unexpected item", 64'd1, 64'd0);
            end else begin
                w = expected_res.pop_front();
                status_hits[w.st]++;
                if (m_result_node !== w.node) report_mismatch("result_node", m_result_node, w.node);
                if (m_data_out !== w.data) report_mismatch("data_out", m_data_out, w.data);
                if (m_item_count !== w.count) report_mismatch("item_count", m_item_count, w.count);
                if (m_status !== w.st) report_mismatch("status", m_status, w.st);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WDOG_MAX) begin
            $display("Timeout: nothing moved for %0d cycles", WDOG_MAX);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void queue_op(func_t fn, int nd, int pos, logic [63:0] v);
        op_t o;
        o.fn = fn;
        o.node = 8'(nd);
        o.pos = 8'(pos);
        o.val = v;
        pending_ops.push_back(o);
    endfunction

    // random node that already holds data, or 0
    function automatic int written_node();
        int k;
        for (int t = 0; t < 16; t++) begin
            k = $urandom_range(1, N - 1);
            if (written[k]) return k;
        end
        return 0;
    endfunction

    task automatic drain();
        while (pending_ops.size() > 0 || s_valid || expected_res.size() > 0) @(posedge aclk);
    endtask

    task automatic random_batch(int n, bit grow);
        int live [$];
        int it;
        int k;
        int pick;
        int ins_pct;
        live = {};
        it = head_n;
        for (int s = 0; s < N && it != 0; s++) begin
            if (written[it]) live.push_back(it);
            it = nxt_lnk[it];
        end
        ins_pct = grow ? 75 : 25;
        for (int i = 0; i < n; i++) begin
            pick = (live.size() > 0) ? live[$urandom_range(0, live.size() - 1)] : 0;
            k = $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0) begin
                // noise: arbitrary anchors, null nodes, stale extracts
                case ($urandom_range(0, 2))
                    0: queue_op(FN_INS_AFTER, $urandom_range(0, N - 1), $urandom, rand_word());
                    1: queue_op(FN_INS_BEFORE, $urandom_range(0, 1) ? 0 : $urandom_range(0, N - 1),
                                $urandom, rand_word());
                    default: queue_op(FN_EXTRACT, $urandom_range(0, 1) ? 0 : written_node(),
                                      $urandom, rand_word());
                endcase
            end else if (k < ins_pct) begin
                if ($urandom_range(0, 1)) begin
                    queue_op(FN_INS_AFTER, $urandom_range(0, 4) == 0 ? 0 : pick,
                             $urandom, rand_word());
                end else begin
                    queue_op(FN_INS_BEFORE, pick, $urandom, rand_word());
                end
            end else if (k < ins_pct + 15) begin
                queue_op(FN_LOCATE, $urandom,
                         $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                    : $urandom_range(0, list_len + 2),
                         rand_word());
            end else begin
                queue_op(FN_EXTRACT, pick, $urandom, rand_word());
                for (int j = 0; j < live.size(); j++) begin
                    if (live[j] == pick) begin
                        live.delete(j);
                        break;
                    end
                end
            end
        end
    endtask

    initial begin
        bit grow;
        int sent;
        shadow_reset();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed
        queue_op(FN_EXTRACT, 1, 0, '0);
        queue_op(FN_LOCATE, 0, 1, '0);
        queue_op(FN_INS_AFTER, 0, 0, '0);
        queue_op(FN_INS_AFTER, 1, 0, '1);
        queue_op(FN_INS_BEFORE, 1, 0, 64'h5555_5555_5555_5555);
        queue_op(FN_INS_BEFORE, 0, 0, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_op(FN_INS_AFTER, 2, 255, 64'h8000_0000_0000_0001);
        queue_op(FN_LOCATE, 0, 0, '0);
        queue_op(FN_LOCATE, 0, 1, '0);
        queue_op(FN_LOCATE, 0, 4, '0);
        queue_op(FN_LOCATE, 0, 5, '0);
        queue_op(FN_LOCATE, 255, 255, '1);
        queue_op(FN_EXTRACT, 0, 0, '0);
        queue_op(FN_EXTRACT, 3, 0, '0);
        queue_op(FN_EXTRACT, 1, 0, '0);
        queue_op(FN_EXTRACT, 4, 0, '0);
        queue_op(FN_EXTRACT, 2, 0, '0);
        queue_op(FN_EXTRACT, 2, 0, '0);
        queue_op(FN_LOCATE, 0, 1, '0);
        drain();

        // random: alternate growing to full and shrinking to empty
        grow = 1;
        sent = 0;
        while (sent < 1200) begin
            random_batch(20, grow);
            sent += 20;
            drain();
            if (grow && list_len >= N - 1) grow = 0;
            else if (!grow && list_len == 0) grow = 1;
        end

        drain();
        repeat (600) @(posedge aclk);
        $display("Covered %0d results, peak list length %0d", results_seen, peak_len);
        $display("Status counts ok/full/empty/null/notfound: %0d %0d %0d %0d %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4]);
        if (errors == 0 && expected_res.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/alm_pkg.sv
rtl/alm_ram.sv
rtl/array_linked_list_manager.sv
test/array_linked_list_manager_tb.sv
